@@ design/wdwr_pkg.sv @@
// Shared types, widths and codes for the weighted draw without replacement block.
// No dependencies; compiled first.
package wdwr_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int FUNC_W   = 2;
	localparam int KEY_W    = 32;
	localparam int WEIGHT_W = 16;
	localparam int RND_W    = 31;
	localparam int STATUS_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DRAW   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DRAWN     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

	// One table row: taken mark, weight, key.
	typedef struct packed {
		logic                taken;
		logic [WEIGHT_W-1:0] weight;
		logic [KEY_W-1:0]    key;
	} entry_t;

endpackage

@@ design/wdwr_req_if.sv @@
// Request channel: valid/ready handshake carrying one operation.
// Depends on wdwr_pkg for field widths.
interface wdwr_req_if;
	logic                              valid;
	logic                              ready;
	logic [wdwr_pkg::FUNC_W-1:0]       func;
	logic signed [wdwr_pkg::KEY_W-1:0] entry_key;
	logic [wdwr_pkg::WEIGHT_W-1:0]     weight;
	logic [wdwr_pkg::RND_W-1:0]        random_word;

	modport source (output valid, func, entry_key, weight, random_word, input ready);
	modport sink   (input valid, func, entry_key, weight, random_word, output ready);
endinterface

@@ design/wdwr_rsp_if.sv @@
// Response channel: valid/ready handshake carrying status and drawn key.
// Depends on wdwr_pkg for field widths.
interface wdwr_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [wdwr_pkg::STATUS_W-1:0]     status;
	logic signed [wdwr_pkg::KEY_W-1:0] drawn_key;

	modport source (output valid, status, drawn_key, input ready);
	modport sink   (input valid, status, drawn_key, output ready);
endinterface

@@ design/weighted_draw_without_replacement.sv @@
// Top level of the weighted draw without replacement block.
// Depends on wdwr_pkg, wdwr_req_if and wdwr_rsp_if.
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-----------
//  req     | in  | func, entry_key, weight, random_word      | valid/ready
//  rsp     | out | status, drawn_key                         | valid/ready
//
// Clear and append go straight from the accept to the response state. A draw with
// entries left runs a 31-step bit-serial remainder (S_DIV), then a walk (S_WALK)
// reading one table row per cycle from the single-port-read table memory, then
// the response register load (S_RESP).
// Reset clears counts and state; the table memory is not cleared (rows below
// entry_count are always written by an append since the last clear).
// A full response register stalls the block in its response state; a new
// request is taken once the previous result has moved to the response register.
module weighted_draw_without_replacement #(
	parameter int CAPACITY = wdwr_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wdwr_req_if.sink  req,
	wdwr_rsp_if.source rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int TOT_W = wdwr_pkg::WEIGHT_W + CNT_W;
	localparam int DCNT_W = $clog2(wdwr_pkg::RND_W);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	// table memory
	wdwr_pkg::entry_t mem [CAPACITY];
	wdwr_pkg::entry_t rdata_s1;
	logic             rd_vld_s1;

	logic [1:0]                        state_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  avail_q;
	logic [TOT_W-1:0]                  total_q;
	logic [TOT_W-1:0]                  rem_q;
	logic [TOT_W-1:0]                  sum_q;
	logic [wdwr_pkg::RND_W-1:0]        dvd_q;
	logic [DCNT_W-1:0]                 dcnt_q;
	logic [CNT_W-1:0]                  rd_idx_q;
	logic [IDX_W-1:0]                  hit_idx_s1;
	logic [wdwr_pkg::STATUS_W-1:0]     res_status_q;
	logic [wdwr_pkg::KEY_W-1:0]        res_key_q;
	logic                              rsp_valid_q;
	logic [wdwr_pkg::STATUS_W-1:0]     rsp_status_q;
	logic [wdwr_pkg::KEY_W-1:0]        rsp_key_q;

	logic                   accept;
	logic                   issue;
	logic                   hit;
	logic                   walk_end;
	logic                   resp_load;
	logic [TOT_W:0]         div_trial;
	logic [TOT_W:0]         div_diff;
	logic [TOT_W-1:0]       sum_new;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	wdwr_pkg::entry_t       wr_data;

	assign req.ready     = (state_q == S_IDLE);
	assign accept        = req.valid && req.ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.drawn_key = rsp_key_q;
	assign resp_load     = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	// one restoring remainder step per cycle
	assign div_trial = {rem_q, dvd_q[wdwr_pkg::RND_W-1]};
	assign div_diff  = div_trial - {1'b0, total_q};

	// walk: issue one row read per cycle, test the row read last cycle
	assign issue    = (state_q == S_WALK) && (rd_idx_q < count_q);
	assign sum_new  = sum_q + TOT_W'(rdata_s1.weight);
	assign hit      = (state_q == S_WALK) && rd_vld_s1 && !rdata_s1.taken &&
	                  (rem_q < sum_new);
	assign walk_end = (state_q == S_WALK) && !rd_vld_s1 && !issue;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_idx_s1;
		wr_data = '{taken: 1'b1, weight: rdata_s1.weight, key: rdata_s1.key};
		if (hit) begin
			wr_en = 1'b1;
		end else if (accept && req.func == wdwr_pkg::FUNC_APPEND && count_q < CAP_C) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IDX_W-1:0];
			wr_data = '{taken: 1'b0, weight: req.weight, key: req.entry_key};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1   <= mem[rd_idx_q[IDX_W-1:0]];
		hit_idx_s1 <= rd_idx_q[IDX_W-1:0];
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			dvd_q  <= req.random_word;
			dcnt_q <= DCNT_W'(wdwr_pkg::RND_W - 1);
			rem_q  <= '0;
		end else if (state_q == S_DIV) begin
			dvd_q  <= dvd_q << 1;
			dcnt_q <= dcnt_q - 1'b1;
			rem_q  <= div_diff[TOT_W] ? div_trial[TOT_W-1:0] : div_diff[TOT_W-1:0];
		end
		if (state_q == S_DIV) begin
			sum_q <= '0;
		end else if (state_q == S_WALK && rd_vld_s1 && !rdata_s1.taken) begin
			sum_q <= sum_new;
		end
		if (resp_load) begin
			rsp_status_q <= res_status_q;
			rsp_key_q    <= res_key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			avail_q      <= '0;
			total_q      <= '0;
			rd_idx_q     <= '0;
			rd_vld_s1    <= 1'b0;
			res_status_q <= wdwr_pkg::ST_EXHAUSTED;
			res_key_q    <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (resp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_key_q <= '0;
						case (req.func)
							wdwr_pkg::FUNC_CLEAR: begin
								count_q      <= '0;
								avail_q      <= '0;
								total_q      <= '0;
								res_status_q <= wdwr_pkg::ST_CLEARED;
								state_q      <= S_RESP;
							end
							wdwr_pkg::FUNC_APPEND: begin
								if (count_q < CAP_C) begin
									count_q      <= count_q + 1'b1;
									avail_q      <= avail_q + 1'b1;
									total_q      <= total_q + TOT_W'(req.weight);
									res_status_q <= wdwr_pkg::ST_APPENDED;
								end else begin
									res_status_q <= wdwr_pkg::ST_FULL;
								end
								state_q <= S_RESP;
							end
							wdwr_pkg::FUNC_DRAW: begin
								res_status_q <= wdwr_pkg::ST_EXHAUSTED;
								if (avail_q != '0 && total_q != '0) begin
									state_q <= S_DIV;
								end else begin
									state_q <= S_RESP;
								end
							end
							default: begin
								// unused code: no state change, no response
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_DIV: begin
					if (dcnt_q == '0) begin
						rd_idx_q <= '0;
						state_q  <= S_WALK;
					end
				end
				S_WALK: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (hit) begin
						total_q      <= total_q - TOT_W'(rdata_s1.weight);
						avail_q      <= avail_q - 1'b1;
						res_key_q    <= rdata_s1.key;
						res_status_q <= wdwr_pkg::ST_DRAWN;
						state_q      <= S_RESP;
					end else if (walk_end) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// bookkeeping invariants
	a_avail_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		avail_q <= count_q)
		else $error("available count exceeds entry count");

	a_empty_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(avail_q == '0) |-> (total_q == '0))
		else $error("nonzero total with no available entries");

	a_rem_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (rem_q < total_q))
		else $error("draw target not below remaining total");

	a_hit_updates_avail: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> (avail_q == $past(avail_q) - 1'b1))
		else $error("draw hit did not retire one entry");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for weighted_draw_without_replacement: directed, fill, backpressure
// and random request streams are checked against an in-bench table predictor.
// Depends on wdwr_pkg, wdwr_req_if, wdwr_rsp_if and the block RTL.
module tb_top;

	localparam int TABLE_DEPTH     = wdwr_pkg::CAPACITY_DEF;
	localparam int TBL_IDX_W       = $clog2(TABLE_DEPTH);
	localparam int ITEM_TARGET     = 1800;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 150;
	localparam int CYCLE_LIMIT     = 1_500_000;

	typedef logic [wdwr_pkg::FUNC_W-1:0]   func_t;
	typedef logic [wdwr_pkg::WEIGHT_W-1:0] weight_t;
	typedef logic [wdwr_pkg::RND_W-1:0]    word_t;

	// func code the block ignores: accepted, no response
	localparam func_t FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [wdwr_pkg::STATUS_W-1:0] status;
		logic [wdwr_pkg::KEY_W-1:0]    key;
	} outcome_t;

	logic clk;
	logic arst_n;

	wdwr_req_if req_ch ();
	wdwr_rsp_if rsp_ch ();

	weighted_draw_without_replacement uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// ------------------------------------------------------------------
	// Predictor state: mirror of the table, totals and taken marks
	// ------------------------------------------------------------------
	logic [wdwr_pkg::KEY_W-1:0] tbl_key    [TABLE_DEPTH];
	weight_t                    tbl_weight [TABLE_DEPTH];
	bit                         tbl_taken  [TABLE_DEPTH];
	logic [6:0]                 tbl_count;
	logic [21:0]                tbl_total;
	logic [6:0]                 tbl_avail;

	outcome_t pending_outcomes [$];

	int  mismatch_count = 0;
	int  request_count  = 0;
	int  cycle_count    = 0;
	bit  snd_idle_on    = 1'b0;
	bit  rsp_stall_on   = 1'b0;
	bit  hold_off_req   = 1'b0;

	// ------------------------------------------------------------------
	// Clock, reset, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("MISMATCH t=%0t: %s", $time, what);
	endtask

	// Idle length: mostly none or short, now and then a long one.
	function automatic int pick_gap(input bit enable);
		int roll;
		roll = $urandom_range(0, 99);
		if (!enable)
			return 0;
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Weight mix: zero, max, tiny and full range so both modulo and walk get exercised.
	function automatic weight_t rand_weight();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return '0;
			1: return '1;
			2, 3, 4: return weight_t'($urandom_range(1, 15));
			default: return weight_t'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic word_t rand_word();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return '0;
			1: return '1;
			default: return word_t'($urandom());
		endcase
	endfunction

	// Apply one accepted request to the mirrored table and queue its response.
	task automatic predict_outcome(input func_t op, input logic [wdwr_pkg::KEY_W-1:0] key,
			input weight_t wt, input word_t word);
		outcome_t    exp_res;
		logic [21:0] target;
		logic [21:0] running;
		bit          found;
		exp_res.status = wdwr_pkg::ST_EXHAUSTED;
		exp_res.key    = '0;
		case (op)
			wdwr_pkg::FUNC_CLEAR: begin
				// stores keep their contents, only bookkeeping resets
				for (int i = 0; i < TABLE_DEPTH; i++)
					tbl_taken[i] = 1'b0;
				tbl_count      = '0;
				tbl_total      = '0;
				tbl_avail      = '0;
				exp_res.status = wdwr_pkg::ST_CLEARED;
			end
			wdwr_pkg::FUNC_APPEND: begin
				if (tbl_count >= TABLE_DEPTH) begin
					exp_res.status = wdwr_pkg::ST_FULL;
				end else begin
					tbl_key[tbl_count[TBL_IDX_W-1:0]]    = key;
					tbl_weight[tbl_count[TBL_IDX_W-1:0]] = wt;
					tbl_taken[tbl_count[TBL_IDX_W-1:0]]  = 1'b0;
					tbl_total      = tbl_total + wt;
					tbl_count      = tbl_count + 1'b1;
					tbl_avail      = tbl_avail + 1'b1;
					exp_res.status = wdwr_pkg::ST_APPENDED;
				end
			end
			wdwr_pkg::FUNC_DRAW: begin
				// zero total or nothing left: exhausted, no division happens
				if (tbl_avail != 0 && tbl_total != 0) begin
					target  = 22'(word % tbl_total);
					running = '0;
					found   = 1'b0;
					for (int i = 0; i < tbl_count && !found; i++) begin
						if (!tbl_taken[i]) begin
							running = running + tbl_weight[i];
							if (target < running) begin
								found          = 1'b1;
								tbl_taken[i]   = 1'b1;
								tbl_total      = tbl_total - tbl_weight[i];
								tbl_avail      = tbl_avail - 1'b1;
								exp_res.key    = tbl_key[i];
								exp_res.status = wdwr_pkg::ST_DRAWN;
							end
						end
					end
				end
			end
			default: return;   // ignored code, nothing comes back
		endcase
		pending_outcomes.push_back(exp_res);
	endtask

	// Offer one request from a falling edge; returns at a falling edge after
	// the handshake plus any idle gap. Valid is touched at most once per step.
	task automatic send_request(input func_t op,
			input logic signed [wdwr_pkg::KEY_W-1:0] key,
			input weight_t wt, input word_t word);
		int gap;
		req_ch.valid       <= 1'b1;
		req_ch.func        <= op;
		req_ch.entry_key   <= key;
		req_ch.weight      <= wt;
		req_ch.random_word <= word;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predict_outcome(op, key, wt, word);
		if (op != FUNC_UNUSED)
			request_count++;
		@(negedge clk);
		gap = pick_gap(snd_idle_on);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_append(input weight_t wt);
		send_request(wdwr_pkg::FUNC_APPEND, $urandom(), wt, rand_word());
	endtask

	task automatic send_draw(input word_t word);
		send_request(wdwr_pkg::FUNC_DRAW, $urandom(), rand_weight(), word);
	endtask

	// ------------------------------------------------------------------
	// Response side: ready pattern and the hold-off stretch
	// ------------------------------------------------------------------
	initial begin : rsp_ready_drive
		int stall_len;
		bit hold_done;
		hold_done    = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				// long hold: the block fills and must stall the request side
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				stall_len = (rsp_stall_on && $urandom_range(0, 2) == 0) ? pick_gap(1'b1) : 0;
				if (stall_len > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (stall_len - 1) @(negedge clk);
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Compare every accepted response against the oldest pending prediction.
	always @(posedge clk) begin : response_check
		outcome_t exp_res;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("response status=%0d key=%h with nothing pending",
					rsp_ch.status, rsp_ch.drawn_key));
			end else begin
				exp_res = pending_outcomes.pop_front();
				if (rsp_ch.status !== exp_res.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp_ch.status, exp_res.status));
				if (rsp_ch.drawn_key !== exp_res.key)
					report_mismatch($sformatf("drawn_key %h, expected %h",
						rsp_ch.drawn_key, exp_res.key));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Edge cases: empty draw, zero-weight entries, extreme keys and words,
	// ignored func code, clear on an empty table.
	task automatic test_directed();
		send_draw('1);                                  // nothing stored yet
		send_request(wdwr_pkg::FUNC_APPEND, 32'sh8000_0000, '0, '0);
		send_draw('1);                                  // entry present, total zero
		send_request(wdwr_pkg::FUNC_APPEND, 32'sh7FFF_FFFF, '1, '0);
		send_draw('1);                                  // skips the zero-weight row
		send_draw('0);                                  // only zero weight left
		send_request(FUNC_UNUSED, '0, '0, '0);
		send_request(wdwr_pkg::FUNC_CLEAR, '0, '0, '0);
		send_draw('0);                                  // right after clear
		send_request(wdwr_pkg::FUNC_APPEND, -32'sd1, 16'd1, '0);
		send_request(wdwr_pkg::FUNC_APPEND, 32'sd0, '1, '0);
		send_request(wdwr_pkg::FUNC_APPEND, 32'sh1234_5678, 16'd1, '0);
		send_draw(31'd0);                               // first row
		send_draw(31'd65535);                           // last row, past the heavy one
		send_draw(31'd5);
		send_draw('1);                                  // all taken
		send_request(FUNC_UNUSED, '1, '1, '1);
		send_request(wdwr_pkg::FUNC_CLEAR, '1, '1, '1);
		send_request(wdwr_pkg::FUNC_CLEAR, '0, '0, '0); // clear on empty table
	endtask

	// Fill to capacity at max weight (largest total), overflow, then drain it all.
	task automatic test_table_full();
		send_request(wdwr_pkg::FUNC_CLEAR, $urandom(), rand_weight(), rand_word());
		repeat (TABLE_DEPTH) send_append('1);
		repeat (3) send_append(rand_weight());          // dropped, table full
		repeat (TABLE_DEPTH + 2) send_draw(rand_word());
	endtask

	// Receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		snd_idle_on  = 1'b0;
		hold_off_req = 1'b1;
		send_request(wdwr_pkg::FUNC_CLEAR, $urandom(), rand_weight(), rand_word());
		repeat (12) send_append(rand_weight());
		repeat (12) send_draw(rand_word());
	endtask

	// Mostly well-formed clear/fill/draw sequences, some random noise.
	task automatic test_random_sequences();
		int n_app;
		int n_draw;
		while (request_count < ITEM_TARGET) begin
			snd_idle_on  = ($urandom_range(0, 3) != 0);
			rsp_stall_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 80) begin
				send_request(wdwr_pkg::FUNC_CLEAR, $urandom(), rand_weight(), rand_word());
				// small tables keep draws short; a few go past capacity
				n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(40, TABLE_DEPTH + 3)
				                                    : $urandom_range(1, 12);
				repeat (n_app) send_append(rand_weight());
				n_draw = n_app + $urandom_range(0, 2);
				repeat (n_draw) begin
					if ($urandom_range(0, 7) == 0)
						send_append(rand_weight());
					send_draw(rand_word());
				end
			end else begin
				repeat ($urandom_range(1, 10))
					send_request(func_t'($urandom_range(0, 3)), $urandom(), rand_weight(),
						rand_word());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.func        = wdwr_pkg::FUNC_CLEAR;
		req_ch.entry_key   = '0;
		req_ch.weight      = '0;
		req_ch.random_word = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_key[i]    = '0;
			tbl_weight[i] = '0;
			tbl_taken[i]  = 1'b0;
		end
		tbl_count = '0;
		tbl_total = '0;
		tbl_avail = '0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		snd_idle_on  = 1'b1;
		rsp_stall_on = 1'b1;
		test_table_full();
		test_backpressure();
		test_random_sequences();

		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/wdwr_pkg.sv
design/wdwr_req_if.sv
design/wdwr_rsp_if.sv
design/weighted_draw_without_replacement.sv
tb/tb_top.sv
